>>> src/ahrc_pkg.sv
// ----------------------------------------------------------------------------
// ahrc_pkg
// Shared types and constants of the averaged hysteresis relay control.
// ----------------------------------------------------------------------------
package ahrc_pkg;

	localparam int TEMP_W  = 11;
	localparam int HUMID_W = 10;

	// configuration register indexes
	localparam logic [1:0] REG_TEMP_THR  = 2'd0;
	localparam logic [1:0] REG_TEMP_HYS  = 2'd1;
	localparam logic [1:0] REG_HUMID_THR = 2'd2;
	localparam logic [1:0] REG_HUMID_HYS = 2'd3;

	// configuration reset values
	localparam logic signed [10:0] TEMP_THR_RST  = 11'sd200;
	localparam logic [8:0]         TEMP_HYS_RST  = 9'd10;
	localparam logic [9:0]         HUMID_THR_RST = 10'd500;
	localparam logic [9:0]         HUMID_HYS_RST = 10'd50;

	localparam logic [15:0] ERR_MAX = 16'hFFFF;

	// one window entry
	typedef struct packed {
		logic signed [10:0] temp;
		logic [9:0]         humid;
	} sample_t;

	// command from the controller to the window engine
	typedef struct packed {
		logic    start;
		logic    ok;
		sample_t smp;
	} win_cmd_t;

	// status from the window engine
	typedef struct packed {
		logic               done;
		logic signed [10:0] min_t;
		logic signed [10:0] max_t;
		logic [9:0]         min_h;
		logic [9:0]         max_h;
	} win_stat_t;

endpackage

>>> src/ahrc_div.sv
// ----------------------------------------------------------------------------
// ahrc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ahrc_div import ahrc_pkg::*; #(
	parameter int N  = 15,
	parameter int DW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [N-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [N-1:0]  quotient
);

	localparam int CW = $clog2(N + 1);

	logic [DW-1:0] rem_q;
	logic [N-1:0]  quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// trial subtract of the next partial remainder
	always_comb begin
		trial = {rem_q, quo_q[N-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	// control: count down one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(N);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: shift the dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

>>> src/ahrc_win.sv
// ----------------------------------------------------------------------------
// ahrc_win
// Sample window engine: window memory, running sums, fill and write slot,
// and the min/max walk over the held entries.
// ----------------------------------------------------------------------------
module ahrc_win import ahrc_pkg::*; #(
	parameter int WINDOW = 10,
	parameter int AW     = 4,
	parameter int FW     = 4,
	parameter int TSW    = 15,
	parameter int HSW    = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  win_cmd_t              cmd,
	output win_stat_t             stat,
	output logic [FW-1:0]         fill,
	output logic signed [TSW-1:0] temp_sum,
	output logic [HSW-1:0]        humid_sum
);

	localparam logic [1:0] W_IDLE = 2'd0;
	localparam logic [1:0] W_UPD  = 2'd1;
	localparam logic [1:0] W_WALK = 2'd2;

	sample_t               mem_q [WINDOW];
	sample_t               rdata_q;
	sample_t               smp_q;

	logic [1:0]            state_q;
	logic [FW-1:0]         fill_q;
	logic [AW-1:0]         slot_q;
	logic [FW-1:0]         iss_q;
	logic                  pend_q;
	logic                  first_q;
	logic                  done_q;
	logic signed [TSW-1:0] tsum_q;
	logic [HSW-1:0]        hsum_q;
	logic signed [10:0]    min_t_q;
	logic signed [10:0]    max_t_q;
	logic [9:0]            min_h_q;
	logic [9:0]            max_h_q;

	logic                  ren;
	logic [AW-1:0]         raddr;
	logic                  full;

	assign full = (fill_q == FW'(WINDOW));

	// select the read port: old entry at the slot, or the next walk entry
	always_comb begin
		ren   = 1'b0;
		raddr = slot_q;
		if (state_q == W_IDLE && cmd.start && cmd.ok) begin
			ren = 1'b1;
		end else if (state_q == W_WALK && iss_q < fill_q) begin
			ren   = 1'b1;
			raddr = iss_q[AW-1:0];
		end
	end

	// window memory; the slot is read in the cycle before it is overwritten
	always_ff @(posedge clk) begin
		if (state_q == W_UPD) begin
			mem_q[slot_q] <= smp_q;
		end
		if (ren) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// sequencer, sums and extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			smp_q   <= '0;
			fill_q  <= '0;
			slot_q  <= '0;
			iss_q   <= '0;
			pend_q  <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
			tsum_q  <= '0;
			hsum_q  <= '0;
			min_t_q <= '0;
			max_t_q <= '0;
			min_h_q <= '0;
			max_h_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				W_IDLE: begin
					if (cmd.start) begin
						smp_q <= cmd.smp;
						if (cmd.ok) begin
							state_q <= W_UPD;
						end else if (fill_q == '0) begin
							// empty window reports zeros
							min_t_q <= '0;
							max_t_q <= '0;
							min_h_q <= '0;
							max_h_q <= '0;
							done_q  <= 1'b1;
						end else begin
							iss_q   <= '0;
							pend_q  <= 1'b0;
							first_q <= 1'b1;
							state_q <= W_WALK;
						end
					end
				end
				W_UPD: begin
					// retire the overwritten entry once the window is full
					if (full) begin
						tsum_q <= tsum_q - TSW'(rdata_q.temp) + TSW'(smp_q.temp);
						hsum_q <= hsum_q - HSW'(rdata_q.humid) + HSW'(smp_q.humid);
					end else begin
						tsum_q <= tsum_q + TSW'(smp_q.temp);
						hsum_q <= hsum_q + HSW'(smp_q.humid);
						fill_q <= fill_q + 1'b1;
					end
					slot_q  <= (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					iss_q   <= '0;
					pend_q  <= 1'b0;
					first_q <= 1'b1;
					state_q <= W_WALK;
				end
				W_WALK: begin
					// fold the entry read last cycle
					if (pend_q) begin
						first_q <= 1'b0;
						if (first_q || rdata_q.temp < min_t_q) min_t_q <= rdata_q.temp;
						if (first_q || rdata_q.temp > max_t_q) max_t_q <= rdata_q.temp;
						if (first_q || rdata_q.humid < min_h_q) min_h_q <= rdata_q.humid;
						if (first_q || rdata_q.humid > max_h_q) max_h_q <= rdata_q.humid;
					end
					if (iss_q < fill_q) begin
						iss_q  <= iss_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							done_q  <= 1'b1;
							state_q <= W_IDLE;
						end
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	assign stat.done  = done_q;
	assign stat.min_t = min_t_q;
	assign stat.max_t = max_t_q;
	assign stat.min_h = min_h_q;
	assign stat.max_h = max_h_q;
	assign fill       = fill_q;
	assign temp_sum   = tsum_q;
	assign humid_sum  = hsum_q;

endmodule

>>> src/averaged_hysteresis_relay_control.sv
// ----------------------------------------------------------------------------
// averaged_hysteresis_relay_control
// Moving-average thermostat: sliding windows, averages, extremes and a relay
// with hysteresis, plus saturating read error counters.
//
// Channel   Dir  Handshake              Content
// s_*       in   s_tvalid / s_tready    one sensor reading per word
// m_*       out  m_tvalid / m_tready    one status word per reading
// cfg_*     in   cfg_valid / cfg_ready  register index and write data
//
// A good reading passes through these steps from acceptance to its status
// word: the sums are updated, the walk reads one window entry per cycle, the
// averaging divider produces one quotient bit per cycle, and the result is
// handed off and loaded into the output register. The next reading is accepted
// in the cycle after the word is loaded; readings are processed one at a time.
// Reset leaves the window empty and the relay off. A finished word waits in the
// output register; the next reading is accepted meanwhile and held at its end
// until that register is free.
// ----------------------------------------------------------------------------
module averaged_hysteresis_relay_control import ahrc_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // temp_tenths[10:0], humid_tenths[20:11], zero pad
	input  logic         s_tuser,   // reading_valid
	output logic         m_tvalid,
	input  logic         m_tready,
	// relay_on[0], mean_temp[11:1], avg_humid[21:12], window_min_temp[32:22],
	// window_max_temp[43:33], window_min_humid[53:44], window_max_humid[63:54],
	// window_fill[67:64], consecutive_errors[83:68], total_errors[99:84], pad
	output logic [103:0] m_tdata,
	output logic         m_tuser,   // reading_ok
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [10:0]  cfg_data
);

	localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW  = $clog2(WINDOW + 1);
	localparam int TSW = TEMP_W + FW;
	localparam int HSW = HUMID_W + FW;

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_WIN  = 2'd1;
	localparam logic [1:0] T_DIV  = 2'd2;
	localparam logic [1:0] T_OUT  = 2'd3;

	logic [1:0]            state_q;
	logic                  ok_q;
	logic                  neg_q;
	logic                  relay_q;
	logic [15:0]           err_run_q;
	logic [15:0]           err_tot_q;
	logic signed [10:0]    avg_t_q;
	logic [9:0]            avg_h_q;
	logic                  m_tvalid_q;
	logic [103:0]          m_tdata_q;
	logic                  m_tuser_q;

	logic signed [10:0]    temp_thr_q;
	logic [8:0]            temp_hys_q;
	logic [9:0]            humid_thr_q;
	logic [9:0]            humid_hys_q;

	win_cmd_t              win_cmd;
	win_stat_t             win_stat;
	logic [FW-1:0]         win_fill;
	logic signed [TSW-1:0] win_tsum;
	logic [HSW-1:0]        win_hsum;

	logic                  div_start;
	logic [TSW-1:0]        tmag;
	logic                  tdiv_busy;
	logic                  hdiv_busy;
	logic [TSW-1:0]        tquo;
	logic [HSW-1:0]        hquo;

	logic                  in_acc;
	logic                  out_free;
	logic signed [10:0]    avg_t_c;
	logic [9:0]            avg_h_c;
	logic signed [12:0]    t_avg_x;
	logic signed [12:0]    t_thr_x;
	logic signed [12:0]    t_off_x;
	logic signed [11:0]    h_avg_x;
	logic signed [11:0]    h_thr_x;
	logic signed [11:0]    h_off_x;
	logic                  relay_n;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == T_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_thr_q  <= TEMP_THR_RST;
			temp_hys_q  <= TEMP_HYS_RST;
			humid_thr_q <= HUMID_THR_RST;
			humid_hys_q <= HUMID_HYS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TEMP_THR:  temp_thr_q  <= cfg_data;
				REG_TEMP_HYS:  temp_hys_q  <= cfg_data[8:0];
				REG_HUMID_THR: humid_thr_q <= cfg_data[9:0];
				REG_HUMID_HYS: humid_hys_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// window engine
	assign win_cmd.start     = in_acc;
	assign win_cmd.ok        = s_tuser;
	assign win_cmd.smp.temp  = s_tdata[10:0];
	assign win_cmd.smp.humid = s_tdata[20:11];

	ahrc_win #(
		.WINDOW (WINDOW),
		.AW     (AW),
		.FW     (FW),
		.TSW    (TSW),
		.HSW    (HSW)
	) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (win_cmd),
		.stat      (win_stat),
		.fill      (win_fill),
		.temp_sum  (win_tsum),
		.humid_sum (win_hsum)
	);

	// averaging dividers on magnitudes
	assign div_start = (state_q == T_WIN) && win_stat.done && (win_fill != '0);
	assign tmag      = (win_tsum < 0) ? TSW'(-win_tsum) : TSW'(win_tsum);

	ahrc_div #(
		.N  (TSW),
		.DW (FW)
	) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tmag),
		.divisor  (win_fill),
		.busy     (tdiv_busy),
		.quotient (tquo)
	);

	ahrc_div #(
		.N  (HSW),
		.DW (FW)
	) u_hdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (win_hsum),
		.divisor  (win_fill),
		.busy     (hdiv_busy),
		.quotient (hquo)
	);

	// restore sign of the average and evaluate the hysteresis
	always_comb begin
		avg_t_c = neg_q ? 11'(-tquo) : 11'(tquo);
		avg_h_c = 10'(hquo);
		t_avg_x = 13'(avg_t_c);
		t_thr_x = 13'(temp_thr_q);
		t_off_x = t_thr_x - 13'(temp_hys_q);
		h_avg_x = 12'(avg_h_c);
		h_thr_x = 12'(humid_thr_q);
		h_off_x = h_thr_x - 12'(humid_hys_q);
		if (relay_q) begin
			relay_n = !(t_avg_x <= t_off_x || h_avg_x < h_off_x);
		end else begin
			relay_n = (t_avg_x >= t_thr_x) && (h_avg_x >= h_thr_x);
		end
	end

	// item sequencer, counters, relay and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			ok_q       <= 1'b0;
			neg_q      <= 1'b0;
			relay_q    <= 1'b0;
			err_run_q  <= '0;
			err_tot_q  <= '0;
			avg_t_q    <= '0;
			avg_h_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != T_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						ok_q <= s_tuser;
						if (s_tuser) begin
							err_run_q <= '0;
						end else begin
							if (err_run_q != ERR_MAX) err_run_q <= err_run_q + 1'b1;
							if (err_tot_q != ERR_MAX) err_tot_q <= err_tot_q + 1'b1;
						end
						state_q <= T_WIN;
					end
				end
				T_WIN: begin
					if (win_stat.done) begin
						if (win_fill != '0) begin
							neg_q   <= (win_tsum < 0);
							state_q <= T_DIV;
						end else begin
							avg_t_q <= '0;
							avg_h_q <= '0;
							state_q <= T_OUT;
						end
					end
				end
				T_DIV: begin
					if (!tdiv_busy && !hdiv_busy) begin
						avg_t_q <= avg_t_c;
						avg_h_q <= avg_h_c;
						if (ok_q) begin
							relay_q <= relay_n;
						end
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= ok_q;
						m_tdata_q  <= {4'b0, err_tot_q, err_run_q, 4'(win_fill),
							win_stat.max_h, win_stat.min_h,
							win_stat.max_t, win_stat.min_t,
							avg_h_q, avg_t_q, relay_q};
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	// a run of errors never exceeds the total since reset
	assert property (@(posedge clk) disable iff (!arst_n) err_run_q <= err_tot_q)
		else $error("consecutive error count exceeds total");

	// the window never holds more than WINDOW samples
	assert property (@(posedge clk) disable iff (!arst_n) win_fill <= FW'(WINDOW))
		else $error("window fill beyond depth");

	// the relay moves only on a good reading
	assert property (@(posedge clk) disable iff (!arst_n)
		(relay_q != $past(relay_q)) |-> ok_q)
		else $error("relay changed on a failed reading");

	// an accepted reading starts the window engine
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == T_WIN))
		else $error("accepted reading not dispatched");
`endif

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the moving-average thermostat. Sensor words go in
// through the stream slave port; a local model of the windows, the averages,
// the extremes, the relay hysteresis and the error counters predicts every
// status word, and each status word is compared field by field with the oldest
// prediction. A short directed table runs first on the reset thresholds, then
// random-walk readings run under several threshold settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top import ahrc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_DEPTH = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PHASE_READINGS = 104;

	// one status word, split into fields
	typedef struct packed {
		logic               relay_on;
		logic               reading_ok;
		logic signed [10:0] mean_temp;
		logic [9:0]         avg_humid;
		logic signed [10:0] min_temp;
		logic signed [10:0] max_temp;
		logic [9:0]         min_humid;
		logic [9:0]         max_humid;
		logic [3:0]         fill;
		logic [15:0]        err_run;
		logic [15:0]        err_total;
	} status_t;

	// one row of the directed table
	typedef struct {
		logic               ok;
		logic signed [10:0] temp;
		logic [9:0]         humid;
		logic               typed;
		status_t            want;
	} reading_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [23:0]  s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic         m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [10:0]  cfg_data;

	// thermostat model state
	logic signed [10:0] temp_hist [WIN_DEPTH];
	logic [9:0]         humid_hist [WIN_DEPTH];
	int                 temp_acc = 0;
	int                 humid_acc = 0;
	int                 n_held = 0;
	int                 next_slot = 0;
	logic               relay_model = 1'b0;
	int                 run_errs = 0;
	int                 all_errs = 0;

	// threshold registers as the model sees them
	logic signed [10:0] thr_temp = 11'sd200;
	logic [8:0]         hys_temp = 9'd10;
	logic [9:0]         thr_humid = 10'd500;
	logic [9:0]         hys_humid = 10'd50;

	status_t      pending_status [$];
	reading_row_t dir_rows [$];
	int           mismatches = 0;
	int           tx_idle_pct = 0;
	int           rx_idle_pct = 0;
	logic         hold_req = 1'b0;

	averaged_hysteresis_relay_control dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// advance the thermostat model by one reading, return the status word
	function automatic status_t thermo_step(input logic ok, input logic signed [10:0] t,
			input logic [9:0] h);
		status_t r;
		int s;
		int at;
		int ah;
		r = '0;
		at = 0;
		ah = 0;
		if (!ok) begin
			if (run_errs < 65535) run_errs++;
			if (all_errs < 65535) all_errs++;
		end else begin
			run_errs = 0;
			s = next_slot;
			// drop the oldest sample once the window is full
			if (n_held >= WIN_DEPTH) begin
				temp_acc -= temp_hist[s];
				humid_acc -= humid_hist[s];
			end else begin
				n_held++;
			end
			temp_hist[s] = t;
			humid_hist[s] = h;
			temp_acc += t;
			humid_acc += h;
			next_slot = (s + 1 >= WIN_DEPTH) ? 0 : s + 1;
		end
		if (n_held > 0) begin
			at = temp_acc / n_held;
			ah = humid_acc / n_held;
			r.min_temp = temp_hist[0];
			r.max_temp = temp_hist[0];
			r.min_humid = humid_hist[0];
			r.max_humid = humid_hist[0];
			for (int i = 1; i < n_held; i++) begin
				if (temp_hist[i] < r.min_temp) r.min_temp = temp_hist[i];
				if (temp_hist[i] > r.max_temp) r.max_temp = temp_hist[i];
				if (humid_hist[i] < r.min_humid) r.min_humid = humid_hist[i];
				if (humid_hist[i] > r.max_humid) r.max_humid = humid_hist[i];
			end
		end
		// relay hysteresis, only after a good reading
		if (ok) begin
			if (relay_model) begin
				if (at <= int'(thr_temp) - int'(hys_temp) ||
						ah < int'(thr_humid) - int'(hys_humid))
					relay_model = 1'b0;
			end else if (at >= int'(thr_temp) && ah >= int'(thr_humid)) begin
				relay_model = 1'b1;
			end
		end
		r.relay_on = relay_model;
		r.reading_ok = ok;
		r.mean_temp = at[10:0];
		r.avg_humid = ah[9:0];
		r.fill = n_held[3:0];
		r.err_run = run_errs[15:0];
		r.err_total = all_errs[15:0];
		return r;
	endfunction

	// offer one sensor word, predict its status word on acceptance
	task automatic send_reading(input logic ok, input logic signed [10:0] t, input logic [9:0] h,
			input logic typed, input status_t want);
		status_t pred;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = ok;
		s_tdata = {3'b000, h, t};
		do @(posedge clk); while (!s_tready);
		pred = thermo_step(ok, t, h);
		pending_status.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic add_row(input logic ok, input logic signed [10:0] t, input logic [9:0] h);
		reading_row_t row;
		row.ok = ok;
		row.temp = t;
		row.humid = h;
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endtask

	// write one register word, keep cfg_valid high for a following write
	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TEMP_THR:  thr_temp = val;
			REG_TEMP_HYS:  hys_temp = val[8:0];
			REG_HUMID_THR: thr_humid = val[9:0];
			REG_HUMID_HYS: hys_humid = val[9:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_thresholds(input logic [10:0] t_thr, input logic [10:0] t_hys,
			input logic [10:0] h_thr, input logic [10:0] h_hys);
		write_reg(REG_TEMP_THR, t_thr);
		write_reg(REG_TEMP_HYS, t_hys);
		write_reg(REG_HUMID_THR, h_thr);
		write_reg(REG_HUMID_HYS, h_hys);
		cfg_valid = 1'b0;
	endtask

	// random-walk readings with failed bursts and full-range noise
	task automatic run_random(input int n, input logic hold);
		int tw;
		int hw;
		int burst;
		logic ok;
		logic signed [10:0] t;
		logic [9:0] h;
		tw = $urandom_range(0, 1200) - 400;
		hw = $urandom_range(0, 1000);
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (hold && i == n / 2) hold_req = 1'b1;
			if (burst > 0) begin
				ok = 1'b0;
				burst--;
			end else if ($urandom_range(0, 99) < 10) begin
				ok = 1'b0;
				if ($urandom_range(0, 7) == 0) burst = $urandom_range(3, 15);
			end else begin
				ok = 1'b1;
			end
			if ($urandom_range(0, 15) == 0) begin
				tw = $urandom_range(0, 1200) - 400;
				hw = $urandom_range(0, 1000);
			end else begin
				tw += $urandom_range(0, 80) - 40;
				hw += $urandom_range(0, 120) - 60;
				if (tw < -400) tw = -400;
				if (tw > 800) tw = 800;
				if (hw < 0) hw = 0;
				if (hw > 1000) hw = 1000;
			end
			t = tw[10:0];
			h = hw[9:0];
			if ($urandom_range(0, 19) == 0) begin
				t = 11'($urandom);
				h = 10'($urandom);
			end
			send_reading(ok, t, h, 1'b0, '0);
		end
	endtask

	task automatic report_field(input string name, input int want, input int seen);
		if (want != seen) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t ns: %s expected %0d actual %0d", $time, name, want, seen);
		end
	endtask

	// receiver: random ready, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				@(negedge clk);
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				@(negedge clk);
			end
			m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// compare each status word with the oldest prediction
	always @(posedge clk) begin : check_status
		status_t seen;
		status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.relay_on = m_tdata[0];
			seen.reading_ok = m_tuser;
			seen.mean_temp = m_tdata[11:1];
			seen.avg_humid = m_tdata[21:12];
			seen.min_temp = m_tdata[32:22];
			seen.max_temp = m_tdata[43:33];
			seen.min_humid = m_tdata[53:44];
			seen.max_humid = m_tdata[63:54];
			seen.fill = m_tdata[67:64];
			seen.err_run = m_tdata[83:68];
			seen.err_total = m_tdata[99:84];
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t ns: status word expected none actual %h", $time, m_tdata);
			end else begin
				want = pending_status.pop_front();
				report_field("relay_on", want.relay_on, seen.relay_on);
				report_field("reading_ok", want.reading_ok, seen.reading_ok);
				report_field("mean_temp", want.mean_temp, seen.mean_temp);
				report_field("avg_humid", want.avg_humid, seen.avg_humid);
				report_field("window_min_temp", want.min_temp, seen.min_temp);
				report_field("window_max_temp", want.max_temp, seen.max_temp);
				report_field("window_min_humid", want.min_humid, seen.min_humid);
				report_field("window_max_humid", want.max_humid, seen.max_humid);
				report_field("window_fill", want.fill, seen.fill);
				report_field("consecutive_errors", want.err_run, seen.err_run);
				report_field("total_errors", want.err_total, seen.err_total);
			end
		end
	end

	// watchdog
	initial begin
		#(20ms);
		$display("averaged_hysteresis_relay_control: mismatch");
		$finish;
	end

	initial begin : main_flow
		reading_row_t row;
		logic [10:0] t_thr;
		logic [10:0] h_thr;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TEMP_THR;
		cfg_data = '0;

		// directed table: empty window, all-ones noise on a failed read,
		// extremes of both fields, wraparound of the window, negative sums
		row.ok = 1'b0; row.temp = 11'sd0; row.humid = 10'd0; row.typed = 1'b1;
		row.want = '{relay_on: 1'b0, reading_ok: 1'b0, mean_temp: 11'sd0, avg_humid: 10'd0,
			min_temp: 11'sd0, max_temp: 11'sd0, min_humid: 10'd0, max_humid: 10'd0,
			fill: 4'd0, err_run: 16'd1, err_total: 16'd1};
		dir_rows.push_back(row);
		row.temp = 11'h7FF; row.humid = 10'h3FF;
		row.want.err_run = 16'd2;
		row.want.err_total = 16'd2;
		dir_rows.push_back(row);
		row.ok = 1'b1; row.temp = 11'sd800; row.humid = 10'd1000;
		row.want = '{relay_on: 1'b1, reading_ok: 1'b1, mean_temp: 11'sd800, avg_humid: 10'd1000,
			min_temp: 11'sd800, max_temp: 11'sd800, min_humid: 10'd1000, max_humid: 10'd1000,
			fill: 4'd1, err_run: 16'd0, err_total: 16'd2};
		dir_rows.push_back(row);
		add_row(1'b1, -11'sd400, 10'd0);
		add_row(1'b1, 11'sd1023, 10'h3FF);
		add_row(1'b1, -11'sd1024, 10'd0);
		add_row(1'b0, 11'sd5, 10'd5);
		add_row(1'b1, 11'sd7, 10'd3);
		add_row(1'b1, -11'sd9, 10'd1);
		add_row(1'b1, 11'sd195, 10'd480);
		add_row(1'b1, 11'sd190, 10'd460);
		add_row(1'b1, 11'sd185, 10'd440);
		add_row(1'b1, 11'sd180, 10'd420);
		add_row(1'b1, 11'sd175, 10'd400);
		add_row(1'b1, 11'sd170, 10'd380);
		add_row(1'b1, -11'sd3, 10'd1);
		add_row(1'b0, 11'sd0, 10'd0);
		add_row(1'b0, 11'h555, 10'h2AA);
		add_row(1'b1, 11'sd0, 10'd0);
		add_row(1'b1, -11'sd400, 10'd1000);
		add_row(1'b1, 11'sd800, 10'd0);
		add_row(1'b1, 11'h2AA, 10'h155);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// walk the table on the reset thresholds
		tx_idle_pct = 6;
		rx_idle_pct = 54;
		foreach (dir_rows[i])
			send_reading(dir_rows[i].ok, dir_rows[i].temp, dir_rows[i].humid,
				dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			// drain before touching the thresholds
			s_tvalid = 1'b0;
			while (pending_status.size() != 0) @(posedge clk);
			@(negedge clk);
			case (p)
				0: set_thresholds(-11'sd400, 11'd0, 11'd0, 11'd0);
				1: set_thresholds(11'sd800, 11'd500, 11'd1000, 11'd1000);
				default: begin
					t_thr = ($urandom_range(0, 7) == 0) ? 11'($urandom)
						: 11'($urandom_range(0, 1200) - 400);
					h_thr = 11'($urandom_range(0, 1000)) | {$urandom_range(0, 1) == 1, 10'd0};
					set_thresholds(t_thr, 11'($urandom), h_thr, 11'($urandom));
				end
			endcase
			tx_idle_pct = (p < 3) ? 6 : (p < 6) ? 54 : 0;
			rx_idle_pct = (p < 3) ? 54 : (p < 6) ? 6 : 0;
			run_random(PHASE_READINGS, p == 0 || p == 4);
		end

		// drop valid, wait out the pipeline
		s_tvalid = 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("averaged_hysteresis_relay_control: match");
		else
			$display("averaged_hysteresis_relay_control: mismatch");
		$finish;
	end

endmodule
